[hw/rtl/dhtis_pkg.sv]
// Shared types and constants for the double-hashing insert/search unit.
package dhtis_pkg;

	localparam int KEY_W = 31;

	// Base of the secondary hash: step = STEP_BASE - (key mod STEP_BASE)
	localparam logic [2:0] STEP_BASE = 3'd7;

	// Request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_FOUND     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic             req_type;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot_index;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_REDUCE,
		S_READ,
		S_CHECK
	} state_t;

endpackage

[hw/rtl/dhtis_ram.sv]
// Generic single-port RAM with registered read data.
module dhtis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/double_hash_table_insert_search_unit.sv]
// Each request uses P probes, P = 1..TABLE_SLOTS, before done rises.
// The key is reduced mod TABLE_SLOTS and mod 7 by reciprocal multiplication on one shared
// multiplier in S_REDUCE, then each probe is a RAM read (S_READ) and a data check (S_CHECK).
// One request at a time: busy stays high until done rises; the next start is taken
// while done is high.
// Reset: a clearing pass writes every slot empty with busy high.
module double_hash_table_insert_search_unit #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dhtis_pkg::req_t req,
	output logic            busy,
	output logic            done,
	output dhtis_pkg::rsp_t rsp
);

	import dhtis_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int SW = ((AW > 3) ? AW : 3) + 1;
	localparam int EW = KEY_W + 1;
	localparam int RW = AW + 1;
	localparam int PW = 2 * KEY_W;

	localparam logic [AW:0]    SLOTS_X    = (AW + 1)'(TABLE_SLOTS);
	localparam logic [SW-1:0]  SLOTS_S    = SW'(TABLE_SLOTS);
	localparam logic [AW-1:0]  LAST_SLOT  = AW'(TABLE_SLOTS - 1);
	localparam logic [CW-1:0]  LAST_PROBE = CW'(TABLE_SLOTS - 1);
	localparam logic [1:0]     RED_LAST   = 2'd2;

	// floor(2^31 / d): the quotient estimate is at most one below the true quotient
	localparam logic [KEY_W-1:0] RECIP_SLOTS = KEY_W'(64'h8000_0000 / 64'(TABLE_SLOTS));
	localparam logic [KEY_W-1:0] RECIP_SEVEN = KEY_W'(64'h8000_0000 / 64'(STEP_BASE));

	state_t state_q, state_d;

	logic             req_type_q;
	logic [KEY_W-1:0] key_q;
	logic [1:0]       red_cnt_q;
	logic [PW-1:0]    prod_q;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    step_q;
	logic [CW-1:0]    probe_cnt_q;
	logic [AW-1:0]    clr_addr_q;
	logic             done_q;
	rsp_t             rsp_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata;
	logic [EW-1:0] ram_rdata;

	dhtis_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Shared multiplier: reciprocal of the table size first, then of seven
	logic [KEY_W-1:0] mul_b;
	logic [PW-1:0]    mul_p;

	always_comb begin
		mul_b = (red_cnt_q == 2'd0) ? RECIP_SLOTS : RECIP_SEVEN;
		mul_p = PW'(key_q) * PW'(mul_b);
	end

	// Remainders from the registered product; one correcting subtract each
	logic [RW-1:0] quo_m;
	logic [RW-1:0] rem_m_x;
	logic [AW-1:0] rem_m;
	logic [3:0]    quo_7;
	logic [3:0]    rem_7_x;
	logic [2:0]    rem_7;

	always_comb begin
		quo_m   = prod_q[KEY_W +: RW];
		rem_m_x = key_q[RW-1:0] - RW'(quo_m * SLOTS_X);
		if (rem_m_x >= SLOTS_X) begin
			rem_m = AW'(rem_m_x - SLOTS_X);
		end else begin
			rem_m = rem_m_x[AW-1:0];
		end
		quo_7   = prod_q[KEY_W +: 4];
		rem_7_x = key_q[3:0] - 4'(quo_7 * {1'b0, STEP_BASE});
		if (rem_7_x >= {1'b0, STEP_BASE}) begin
			rem_7 = 3'(rem_7_x - {1'b0, STEP_BASE});
		end else begin
			rem_7 = rem_7_x[2:0];
		end
	end

	// Probe step, folded below the table size (small tables need several folds)
	logic [2:0]    step_raw;
	logic [SW-1:0] step_w;
	logic [AW-1:0] step_mod;

	always_comb begin
		step_raw = STEP_BASE - rem_7;
		step_w   = SW'(step_raw);
		for (int i = 0; i < 3; i++) begin
			if (step_w >= SLOTS_S) begin
				step_w = step_w - SLOTS_S;
			end
		end
		step_mod = step_w[AW-1:0];
	end

	// Next probe position, wrapped
	logic [AW:0]   pos_sum;
	logic [AW-1:0] pos_next;

	always_comb begin
		pos_sum = {1'b0, pos_q} + {1'b0, step_q};
		if (pos_sum >= SLOTS_X) begin
			pos_next = AW'(pos_sum - SLOTS_X);
		end else begin
			pos_next = pos_sum[AW-1:0];
		end
	end

	// Slot check on the returned RAM data
	logic             rd_valid;
	logic [KEY_W-1:0] rd_key;
	logic             hit_ins;
	logic             hit_key;
	logic             stop_empty;
	logic             last_probe;
	logic             finish;
	logic [AW+3:0]    pos_wide;
	rsp_t             rsp_d;

	always_comb begin
		rd_valid   = ram_rdata[KEY_W];
		rd_key     = ram_rdata[KEY_W-1:0];
		hit_ins    = (req_type_q == REQ_INSERT) && !rd_valid;
		stop_empty = (req_type_q == REQ_SEARCH) && !rd_valid;
		hit_key    = (req_type_q == REQ_SEARCH) && rd_valid && (rd_key == key_q);
		last_probe = (probe_cnt_q == LAST_PROBE);
		finish     = hit_ins || stop_empty || hit_key || last_probe;
		pos_wide   = (AW + 4)'(pos_q);
		if (hit_ins) begin
			rsp_d.status = ST_INSERTED;
		end else if (hit_key) begin
			rsp_d.status = ST_FOUND;
		end else if (req_type_q == REQ_INSERT) begin
			rsp_d.status = ST_FULL;
		end else begin
			rsp_d.status = ST_NOT_FOUND;
		end
		rsp_d.slot_index = (hit_ins || hit_key) ? pos_wide[3:0] : 4'd0;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_REDUCE;
			end
			S_CLEAR: begin
				if (clr_addr_q == LAST_SLOT) state_d = S_IDLE;
			end
			S_REDUCE: begin
				if (red_cnt_q == RED_LAST) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = finish ? S_IDLE : S_READ;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State outputs: busy and RAM port
	always_comb begin
		busy      = (state_q != S_IDLE);
		ram_we    = 1'b0;
		ram_addr  = pos_q;
		ram_wdata = {1'b1, key_q};
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_addr_q;
				ram_wdata = '0;
			end
			S_CHECK: begin
				ram_we = hit_ins;
			end
			S_IDLE, S_REDUCE, S_READ: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			red_cnt_q   <= '0;
			probe_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				S_CLEAR: clr_addr_q <= clr_addr_q + 1'b1;
				S_IDLE:  red_cnt_q  <= '0;
				S_REDUCE: begin
					red_cnt_q   <= red_cnt_q + 1'b1;
					probe_cnt_q <= '0;
				end
				S_CHECK: begin
					if (finish) begin
						done_q <= 1'b1;
					end else begin
						probe_cnt_q <= probe_cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_type_q <= req.req_type;
					key_q      <= req.key;
				end
			end
			S_REDUCE: begin
				prod_q <= mul_p;
				// home slot once the size product is in, step once the seven product is in
				if (red_cnt_q == 2'd1) begin
					pos_q <= rem_m;
				end
				if (red_cnt_q == RED_LAST) begin
					step_q <= step_mod;
				end
			end
			S_CHECK: begin
				if (finish) begin
					rsp_q <= rsp_d;
				end else begin
					pos_q <= pos_next;
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && state_q == S_REDUCE))
		else $error("accepted request did not start reduction");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (probe_cnt_q <= LAST_PROBE))
		else $error("probe count beyond table size");

endmodule
